// ===== rtl/fmd_pkg.sv =====
package fmd_pkg;

    localparam int LENGTH_WIDTH_DEF = 32;
    localparam int CFG_INDEX_W      = 2;
    localparam logic [7:0] MAX_FRAMES_RST = 8'd32;
    localparam logic [7:0] HEARTBEAT_RST  = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEARTBEAT  = 2'd0,
        CFG_MAX_FRAMES = 2'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_HEADER_OK = 3'd1,
        EV_HEARTBEAT = 3'd2,
        EV_NO_DATA   = 3'd3,
        EV_ILLEGAL   = 3'd4,
        EV_TOO_MANY  = 3'd5,
        EV_REQ_OVER  = 3'd6
    } t_event;

    typedef struct packed {
        logic [7:0] beat_method;
        logic [7:0] max_frames;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       frame_end;
        logic       package_end;
        t_event     event_res;
        logic [3:0] version;
        logic [3:0] minor_ver;
        logic [3:0] compress_mode;
        logic [3:0] encrypt_mode;
        logic [7:0] method_code;
        logic [7:0] frame_number;
    } t_result;

    // six-byte magic at the head of a request
    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (pos)
            3'd0: b = 8'h23;
            3'd1: b = 8'h4D;
            3'd2: b = 8'h46;
            3'd3: b = 8'h50;
            3'd4: b = 8'h54;
            3'd5: b = 8'h50;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/fmd_parser.sv =====
module fmd_parser #(
    parameter int LENGTH_WIDTH = fmd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  fmd_pkg::t_cfg    i_cfg,
    output fmd_pkg::t_result o_res
);

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_CONTROL = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DISCARD = 5'b10000
    } t_phase;

    localparam logic [3:0] HP_MAGIC_END = 4'd6;
    localparam logic [3:0] HP_MODES     = 4'd7;
    localparam logic [3:0] HP_METHOD    = 4'd8;
    localparam logic [3:0] HP_COUNT     = 4'd9;
    localparam logic [3:0] HP_BEAT      = 4'd10;

    t_phase                  r_phase, n_phase;
    logic [3:0]              r_header_pos, n_header_pos;
    logic [2:0]              r_len_left, n_len_left;
    logic [LENGTH_WIDTH-1:0] r_accum, n_accum;
    logic [LENGTH_WIDTH-1:0] r_payload_left, n_payload_left;
    logic                    r_more, n_more;
    logic [7:0]              r_fip, n_fip;
    logic [7:0]              r_pkg_idx, n_pkg_idx;
    logic [7:0]              r_pkg_total, n_pkg_total;
    logic [23:0]             r_hdr, n_hdr;

    logic [LENGTH_WIDTH+7:0] accum_shift;
    logic                    end_frame;
    logic                    fe, pe, dvalid;
    fmd_pkg::t_event         ev;

    assign accum_shift = {r_accum, i_byte};

    always_comb begin
        n_phase        = r_phase;
        n_header_pos   = r_header_pos;
        n_len_left     = r_len_left;
        n_accum        = r_accum;
        n_payload_left = r_payload_left;
        n_more         = r_more;
        n_fip          = r_fip;
        n_pkg_idx      = r_pkg_idx;
        n_pkg_total    = r_pkg_total;
        n_hdr          = r_hdr;
        end_frame      = 1'b0;
        fe             = 1'b0;
        pe             = 1'b0;
        dvalid         = 1'b0;
        ev             = fmd_pkg::EV_NONE;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_header_pos < HP_MAGIC_END) begin
                    if (i_byte == fmd_pkg::magic_byte(r_header_pos[2:0])) begin
                        n_header_pos = r_header_pos + 4'd1;
                    end else begin
                        ev = fmd_pkg::EV_ILLEGAL;
                        // a stray '#' can open a fresh magic
                        n_header_pos = (i_byte == fmd_pkg::magic_byte(3'd0)) ? 4'd1 : 4'd0;
                    end
                end else if (r_header_pos == HP_MAGIC_END) begin
                    n_hdr[23:16] = i_byte;
                    n_header_pos = HP_MODES;
                end else if (r_header_pos == HP_MODES) begin
                    n_hdr[15:8]  = i_byte;
                    n_header_pos = HP_METHOD;
                end else if (r_header_pos == HP_METHOD) begin
                    n_hdr[7:0]   = i_byte;
                    n_header_pos = (i_byte == i_cfg.beat_method) ? HP_BEAT : HP_COUNT;
                end else if (r_header_pos == HP_COUNT) begin
                    n_pkg_total = i_byte;
                    if (i_byte == 8'd0) begin
                        ev           = fmd_pkg::EV_NO_DATA;
                        n_header_pos = 4'd0;
                    end else begin
                        ev           = fmd_pkg::EV_HEADER_OK;
                        n_header_pos = 4'd0;
                        n_fip        = 8'd0;
                        n_pkg_idx    = 8'd0;
                        n_phase      = PH_CONTROL;
                    end
                end else if (r_header_pos == HP_BEAT) begin
                    ev           = fmd_pkg::EV_HEARTBEAT;
                    n_header_pos = 4'd0;
                end else begin
                    n_header_pos = 4'd0;
                end
            end
            PH_CONTROL: begin
                if (i_byte[3:2] > 2'd1) begin
                    ev           = fmd_pkg::EV_ILLEGAL;
                    n_phase      = PH_HEADER;
                    n_header_pos = 4'd0;
                end else begin
                    n_more     = i_byte[2];
                    n_len_left = {1'b0, i_byte[1:0]} + 3'd1;
                    n_accum    = '0;
                    n_phase    = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_accum    = accum_shift[LENGTH_WIDTH-1:0];
                n_len_left = (r_len_left != 3'd0) ? r_len_left - 3'd1 : 3'd0;
                if (n_len_left == 3'd0) begin
                    if (r_fip >= i_cfg.max_frames) begin
                        if (n_accum == '0) begin
                            ev           = fmd_pkg::EV_TOO_MANY;
                            n_phase      = PH_HEADER;
                            n_header_pos = 4'd0;
                        end else begin
                            n_payload_left = n_accum;
                            n_phase        = PH_DISCARD;
                        end
                    end else if (n_accum == '0) begin
                        end_frame = 1'b1;
                    end else begin
                        n_payload_left = n_accum;
                        n_phase        = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                dvalid         = 1'b1;
                n_payload_left = (r_payload_left != '0) ?
                                 r_payload_left - LENGTH_WIDTH'(1) : '0;
                if (n_payload_left == '0) begin
                    end_frame = 1'b1;
                end
            end
            PH_DISCARD: begin
                n_payload_left = (r_payload_left != '0) ?
                                 r_payload_left - LENGTH_WIDTH'(1) : '0;
                if (n_payload_left == '0) begin
                    ev           = fmd_pkg::EV_TOO_MANY;
                    n_phase      = PH_HEADER;
                    n_header_pos = 4'd0;
                end
            end
            default: begin
                n_phase      = PH_HEADER;
                n_header_pos = 4'd0;
            end
        endcase

        if (end_frame) begin
            fe = 1'b1;
            if (!r_more) begin
                pe        = 1'b1;
                n_pkg_idx = r_pkg_idx + 8'd1;
                if (n_pkg_idx == r_pkg_total) begin
                    ev           = fmd_pkg::EV_REQ_OVER;
                    n_phase      = PH_HEADER;
                    n_header_pos = 4'd0;
                end else begin
                    n_fip   = 8'd0;
                    n_phase = PH_CONTROL;
                end
            end else begin
                n_fip   = r_fip + 8'd1;
                n_phase = PH_CONTROL;
            end
        end
    end

    always_comb begin
        o_res.data_byte     = dvalid ? i_byte : 8'd0;
        o_res.data_valid    = dvalid;
        o_res.frame_end     = fe;
        o_res.package_end   = pe;
        o_res.event_res     = ev;
        o_res.version       = n_hdr[23:20];
        o_res.minor_ver     = n_hdr[19:16];
        o_res.compress_mode = n_hdr[15:12];
        o_res.encrypt_mode  = n_hdr[11:8];
        o_res.method_code   = n_hdr[7:0];
        o_res.frame_number  = r_fip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_pos   <= 4'd0;
            r_len_left     <= 3'd0;
            r_accum        <= '0;
            r_payload_left <= '0;
            r_more         <= 1'b0;
            r_fip          <= 8'd0;
            r_pkg_idx      <= 8'd0;
            r_pkg_total    <= 8'd0;
            r_hdr          <= 24'd0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_header_pos   <= n_header_pos;
            r_len_left     <= n_len_left;
            r_accum        <= n_accum;
            r_payload_left <= n_payload_left;
            r_more         <= n_more;
            r_fip          <= n_fip;
            r_pkg_idx      <= n_pkg_idx;
            r_pkg_total    <= n_pkg_total;
            r_hdr          <= n_hdr;
        end
    end

    a_hunt_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEADER |-> r_header_pos == 4'd0)
        else $error("header position left set outside header hunting");

    a_pkg_end_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.package_end |-> o_res.frame_end)
        else $error("package end without frame end");

    a_payload_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_PAYLOAD && r_payload_left == LENGTH_WIDTH'(1)
        |=> r_phase != PH_PAYLOAD)
        else $error("payload phase outlived its length");

    a_header_ok_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.event_res == fmd_pkg::EV_HEADER_OK |=> r_phase == PH_CONTROL)
        else $error("accepted header did not move to control byte");

endmodule

// ===== rtl/framed_message_deframer.sv =====
// channel   direction  handshake                 payload
// in        sink       i_in_valid / o_in_ready   i_rx_byte
// out       source     o_out_valid / i_out_ready o_data_byte .. o_frame_number
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One received word per cycle while the output is not stalled. A word sits in the input
// register; the parser steps on it and the result register loads in the same cycle.
// Synchronous active-low reset: parser hunts for a header, config back to defaults.
// An output stall holds the result register; the input register still takes one word.
module framed_message_deframer #(
    parameter int LENGTH_WIDTH = fmd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_data_byte,
    output logic                            o_data_valid,
    output logic                            o_frame_end,
    output logic                            o_package_end,
    output logic [2:0]                      o_event_res,
    output logic [3:0]                      o_version,
    output logic [3:0]                      o_minor_ver,
    output logic [3:0]                      o_compress_mode,
    output logic [3:0]                      o_encrypt_mode,
    output logic [7:0]                      o_method_code,
    output logic [7:0]                      o_frame_number,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fmd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    fmd_pkg::t_result r_res;
    fmd_pkg::t_result res;
    fmd_pkg::t_cfg    r_cfg;
    logic             adv;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    fmd_parser #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (adv),
        .i_byte (r_in_byte),
        .i_cfg  (r_cfg),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_cfg.beat_method <= fmd_pkg::HEARTBEAT_RST;
            r_cfg.max_frames  <= fmd_pkg::MAX_FRAMES_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fmd_pkg::CFG_HEARTBEAT:  r_cfg.beat_method <= i_cfg_data;
                    fmd_pkg::CFG_MAX_FRAMES: r_cfg.max_frames  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_byte     = r_res.data_byte;
    assign o_data_valid    = r_res.data_valid;
    assign o_frame_end     = r_res.frame_end;
    assign o_package_end   = r_res.package_end;
    assign o_event_res     = r_res.event_res;
    assign o_version       = r_res.version;
    assign o_minor_ver     = r_res.minor_ver;
    assign o_compress_mode = r_res.compress_mode;
    assign o_encrypt_mode  = r_res.encrypt_mode;
    assign o_method_code   = r_res.method_code;
    assign o_frame_number  = r_res.frame_number;

endmodule

// ===== bench/deframer_check.sv =====
`timescale 1ns / 100ps

module deframer_check #(
    parameter logic [47:0] SYNC_WORD = 48'h0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  fmd_pkg::t_result                i_result,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [fmd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_payload,
    output int                              o_requests,
    output int                              o_heartbeats,
    output int                              o_faults
);

    localparam int LEN_W = fmd_pkg::LENGTH_WIDTH_DEF;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_CTRL,
        ST_LEN,
        ST_BODY,
        ST_SKIP
    } t_parse_state;

    t_parse_state     parse_st;
    logic [3:0]       hdr_pos;
    logic [2:0]       len_left;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] body_left;
    logic             more_flag;
    logic [7:0]       frame_idx;
    logic [7:0]       pkg_idx;
    logic [7:0]       pkg_total;
    logic [23:0]      hdr_fields;
    logic [7:0]       cfg_heartbeat;
    logic [7:0]       cfg_max_frames;

    fmd_pkg::t_result pending_results[$];
    int               fail_count;
    int               results_checked;
    int               payload_words;
    int               requests_closed;
    int               heartbeats_seen;
    int               faults_seen;

    task automatic go_hunt();
        parse_st = ST_HUNT;
        hdr_pos  = '0;
    endtask

    task automatic close_frame(inout fmd_pkg::t_result r);
        r.frame_end = 1'b1;
        if (!more_flag) begin
            r.package_end = 1'b1;
            pkg_idx = pkg_idx + 8'd1;
            if (pkg_idx == pkg_total) begin
                r.event_res = fmd_pkg::EV_REQ_OVER;
                go_hunt();
            end else begin
                frame_idx = '0;
                parse_st  = ST_CTRL;
            end
        end else begin
            frame_idx = frame_idx + 8'd1;
            parse_st  = ST_CTRL;
        end
    endtask

    // advance the parser by one received word and build the result it produces
    task automatic deframe_step(input logic [7:0] b, output fmd_pkg::t_result r);
        logic [1:0] cont;
        r = '0;
        r.frame_number = frame_idx;
        case (parse_st)
            ST_HUNT: begin
                if (hdr_pos < 4'd6) begin
                    if (b == SYNC_WORD[47 - 8 * int'(hdr_pos) -: 8]) begin
                        hdr_pos = hdr_pos + 4'd1;
                    end else begin
                        r.event_res = fmd_pkg::EV_ILLEGAL;
                        hdr_pos = (b == SYNC_WORD[47:40]) ? 4'd1 : 4'd0;
                    end
                end else if (hdr_pos == 4'd6) begin
                    hdr_fields[23:16] = b;
                    hdr_pos = 4'd7;
                end else if (hdr_pos == 4'd7) begin
                    hdr_fields[15:8] = b;
                    hdr_pos = 4'd8;
                end else if (hdr_pos == 4'd8) begin
                    hdr_fields[7:0] = b;
                    hdr_pos = (b == cfg_heartbeat) ? 4'd10 : 4'd9;
                end else if (hdr_pos == 4'd9) begin
                    pkg_total = b;
                    if (b == 8'd0) begin
                        r.event_res = fmd_pkg::EV_NO_DATA;
                        go_hunt();
                    end else begin
                        r.event_res = fmd_pkg::EV_HEADER_OK;
                        hdr_pos   = '0;
                        frame_idx = '0;
                        pkg_idx   = '0;
                        parse_st  = ST_CTRL;
                    end
                end else if (hdr_pos == 4'd10) begin
                    r.event_res = fmd_pkg::EV_HEARTBEAT;
                    go_hunt();
                end else begin
                    go_hunt();
                end
            end
            ST_CTRL: begin
                cont = b[3:2];
                if (cont > 2'd1) begin
                    r.event_res = fmd_pkg::EV_ILLEGAL;
                    go_hunt();
                end else begin
                    more_flag = cont[0];
                    len_left  = 3'(b[1:0]) + 3'd1;
                    len_acc   = '0;
                    parse_st  = ST_LEN;
                end
            end
            ST_LEN: begin
                len_acc  = LEN_W'({len_acc, b});
                len_left = (len_left != 3'd0) ? len_left - 3'd1 : 3'd0;
                if (len_left == 3'd0) begin
                    if (int'(frame_idx) + 1 > int'(cfg_max_frames)) begin
                        // overflow frame: swallow it, flag on its last word
                        if (len_acc == '0) begin
                            r.event_res = fmd_pkg::EV_TOO_MANY;
                            go_hunt();
                        end else begin
                            body_left = len_acc;
                            parse_st  = ST_SKIP;
                        end
                    end else if (len_acc == '0) begin
                        close_frame(r);
                    end else begin
                        body_left = len_acc;
                        parse_st  = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                r.data_valid = 1'b1;
                r.data_byte  = b;
                body_left = (body_left != '0) ? body_left - LEN_W'(1) : body_left;
                if (body_left == '0) close_frame(r);
            end
            ST_SKIP: begin
                body_left = (body_left != '0) ? body_left - LEN_W'(1) : body_left;
                if (body_left == '0) begin
                    r.event_res = fmd_pkg::EV_TOO_MANY;
                    go_hunt();
                end
            end
            default: go_hunt();
        endcase
        r.version       = hdr_fields[23:20];
        r.minor_ver     = hdr_fields[19:16];
        r.compress_mode = hdr_fields[15:12];
        r.encrypt_mode  = hdr_fields[11:8];
        r.method_code   = hdr_fields[7:0];
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        fmd_pkg::t_result want;
        fmd_pkg::t_result made;
        if (!i_rst_n) begin
            go_hunt();
            len_left       = '0;
            len_acc        = '0;
            body_left      = '0;
            more_flag      = 1'b0;
            frame_idx      = '0;
            pkg_idx        = '0;
            pkg_total      = '0;
            hdr_fields     = '0;
            cfg_heartbeat  = fmd_pkg::HEARTBEAT_RST;
            cfg_max_frames = fmd_pkg::MAX_FRAMES_RST;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == fmd_pkg::CFG_HEARTBEAT) cfg_heartbeat = i_cfg_data;
                else if (i_cfg_index == fmd_pkg::CFG_MAX_FRAMES) cfg_max_frames = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("data_byte", want.data_byte, i_result.data_byte);
                    check_field("data_valid", want.data_valid, i_result.data_valid);
                    check_field("frame_end", want.frame_end, i_result.frame_end);
                    check_field("package_end", want.package_end, i_result.package_end);
                    check_field("event_res", want.event_res, i_result.event_res);
                    check_field("version", want.version, i_result.version);
                    check_field("minor_ver", want.minor_ver, i_result.minor_ver);
                    check_field("compress_mode", want.compress_mode, i_result.compress_mode);
                    check_field("encrypt_mode", want.encrypt_mode, i_result.encrypt_mode);
                    check_field("method_code", want.method_code, i_result.method_code);
                    check_field("frame_number", want.frame_number, i_result.frame_number);
                    results_checked++;
                    if (want.data_valid) payload_words++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_step(i_rx_byte, made);
                pending_results.push_back(made);
                case (made.event_res)
                    fmd_pkg::EV_REQ_OVER:  requests_closed++;
                    fmd_pkg::EV_HEARTBEAT: heartbeats_seen++;
                    fmd_pkg::EV_ILLEGAL, fmd_pkg::EV_TOO_MANY: faults_seen++;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_results.size();
        o_checked    <= results_checked;
        o_payload    <= payload_words;
        o_requests   <= requests_closed;
        o_heartbeats <= heartbeats_seen;
        o_faults     <= faults_seen;
    end

endmodule

// ===== bench/tb_framed_message_deframer.sv =====
`timescale 1ns / 100ps

module tb_framed_message_deframer;

    localparam logic [47:0] SYNC_WORD = 48'h23_4D_46_50_54_50;
    localparam int NUM_SETTINGS = 5;
    localparam int WORDS_PER_SETTING = 310;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic [7:0]                      i_rx_byte   = 8'h00;
    logic                            i_out_ready = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [fmd_pkg::CFG_INDEX_W-1:0] i_cfg_index = fmd_pkg::CFG_HEARTBEAT;
    logic [7:0]                      i_cfg_data  = 8'h00;

    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_cfg_ready;
    logic [7:0] o_data_byte;
    logic       o_data_valid;
    logic       o_frame_end;
    logic       o_package_end;
    logic [2:0] o_event_res;
    logic [3:0] o_version;
    logic [3:0] o_minor_ver;
    logic [3:0] o_compress_mode;
    logic [3:0] o_encrypt_mode;
    logic [7:0] o_method_code;
    logic [7:0] o_frame_number;

    fmd_pkg::t_result dut_result;
    int               fail_count;
    int               pending;
    int               checked;
    int               payload;
    int               requests;
    int               heartbeats;
    int               faults;

    int         words_sent = 0;
    int         burst_left = 0;
    int         cyc = 0;
    logic [7:0] hb_reg;
    logic [7:0] max_reg;

    framed_message_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_byte     (o_data_byte),
        .o_data_valid    (o_data_valid),
        .o_frame_end     (o_frame_end),
        .o_package_end   (o_package_end),
        .o_event_res     (o_event_res),
        .o_version       (o_version),
        .o_minor_ver     (o_minor_ver),
        .o_compress_mode (o_compress_mode),
        .o_encrypt_mode  (o_encrypt_mode),
        .o_method_code   (o_method_code),
        .o_frame_number  (o_frame_number),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    assign dut_result = {o_data_byte, o_data_valid, o_frame_end, o_package_end, o_event_res,
                         o_version, o_minor_ver, o_compress_mode, o_encrypt_mode,
                         o_method_code, o_frame_number};

    deframer_check #(
        .SYNC_WORD (SYNC_WORD)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result     (dut_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_payload    (payload),
        .o_requests   (requests),
        .o_heartbeats (heartbeats),
        .o_faults     (faults)
    );

    always #5 i_clk = ~i_clk;

    // receiver: cycles through always-ready, coin-flip, one-in-three and long stalls
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        case (cyc[10:9])
            2'd0:    i_out_ready <= 1'b1;
            2'd1:    i_out_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    i_out_ready <= (cyc % 3 == 0);
            default: i_out_ready <= (cyc[5:0] >= 6'd24);
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if ((words_sent / 128) % 4 == 3) begin
                gap = 0;
                burst_left = 128;
            end else begin
                gap = $urandom_range(0, 5);
                burst_left = $urandom_range(1, 16);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        burst_left--;
        words_sent++;
    endtask

    // hold off the sender until every word has come back
    task automatic await_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] hb, input logic [7:0] mf);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fmd_pkg::CFG_HEARTBEAT;
        i_cfg_data  <= hb;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_index <= fmd_pkg::CFG_MAX_FRAMES;
        i_cfg_data  <= mf;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        hb_reg  = hb;
        max_reg = mf;
    endtask

    // bad_pos < 0 sends a clean sync sequence and the four header fields
    task automatic send_header(input int bad_pos, input logic [7:0] ver, input logic [7:0] comp,
                               input logic [7:0] meth, input logic [7:0] cnt);
        logic [7:0] b;
        for (int k = 0; k < 6; k++) begin
            b = SYNC_WORD[47 - 8 * k -: 8];
            if (k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            send_byte(b);
        end
        if (bad_pos < 0) begin
            send_byte(ver);
            send_byte(comp);
            send_byte(meth);
            send_byte(cnt);
        end
    endtask

    task automatic send_frame(input bit more, input int flen);
        int nlen;
        logic [7:0] ctrl;
        nlen = (flen > 255) ? $urandom_range(2, 4) : $urandom_range(1, 4);
        ctrl = {4'($urandom), 2'(more), 2'(nlen - 1)};
        send_byte(ctrl);
        for (int k = nlen - 1; k >= 0; k--) send_byte(8'(flen >> (8 * k)));
        repeat (flen) send_byte(8'($urandom));
    endtask

    task automatic send_request();
        int kind;
        int npkg;
        int nfr;
        int flen;
        int pick;
        logic [7:0] meth;
        bit dead;
        kind = $urandom_range(0, 15);
        if (kind == 15) begin
            // line noise while hunting
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            return;
        end
        if (kind == 2) begin
            send_header($urandom_range(0, 5), 8'h00, 8'h00, 8'h00, 8'h00);
            return;
        end
        if (kind == 0) begin
            send_header(-1, 8'($urandom), 8'($urandom), hb_reg, 8'($urandom));
            return;
        end
        do meth = 8'($urandom); while (meth == hb_reg);
        npkg = (kind == 1) ? 0 : $urandom_range(1, 3);
        send_header(-1, 8'($urandom), 8'($urandom), meth, 8'(npkg));
        dead = 1'b0;
        for (int p = 0; p < npkg && !dead; p++) begin
            nfr = $urandom_range(1, 4);
            for (int f = 0; f < nfr && !dead; f++) begin
                if ($urandom_range(0, 39) == 0) await_idle();
                if ($urandom_range(0, 29) == 0) begin
                    // illegal continue flag kills the request
                    send_byte({4'($urandom), 2'($urandom_range(2, 3)), 2'($urandom)});
                    dead = 1'b1;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) flen = $urandom_range(0, 5);
                    else if (pick < 99) flen = $urandom_range(6, 40);
                    else flen = $urandom_range(256, 300);
                    send_frame(f < nfr - 1, flen);
                    dead = (f >= int'(max_reg));
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        hb_reg  = fmd_pkg::HEARTBEAT_RST;
        max_reg = fmd_pkg::MAX_FRAMES_RST;

        // sync restart on a second '#', then a heartbeat request
        send_byte(SYNC_WORD[47:40]);
        send_header(-1, 8'hFF, 8'h00, 8'h00, 8'hFF);
        // zero package count
        send_header(-1, 8'h00, 8'hFF, 8'h01, 8'h00);
        // one package, one empty frame
        send_header(-1, 8'h12, 8'h34, 8'h80, 8'h01);
        send_frame(1'b0, 0);
        send_byte(8'hA5);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                await_idle();
                case (s)
                    1:       set_config(8'hFF, 8'd1);
                    2:       set_config(8'($urandom), 8'd255);
                    3:       set_config(8'h00, 8'd2);
                    default: set_config(8'($urandom), 8'($urandom_range(3, 6)));
                endcase
            end
            while (words_sent < (s + 1) * WORDS_PER_SETTING) send_request();
        end

        await_idle();
        repeat (8) @(posedge i_clk);
        $display("Drove %0d words over %0d register settings; %0d results compared, %0d payload.",
                 words_sent, NUM_SETTINGS, checked, payload);
        $display("Requests closed %0d, heartbeats %0d, illegal or overflow events %0d.",
                 requests, heartbeats, faults);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
